// ===== src/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the positional list table.
// ----------------------------------------------------------------------------
package plt_pkg;

	localparam int DEFAULT_LIST_DEPTH   = 64;
	localparam int DEFAULT_ELEMENT_BITS = 32;

	localparam int KIND_W    = 3;
	localparam int POS_W     = 6;
	localparam int DATA_W    = 32;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_REMOVE = 3'd2,
		KIND_READ   = 3'd3,
		KIND_REWIND = 3'd4,
		KIND_NEXT   = 3'd5
	} kind_t;

	typedef struct packed {
		logic [DATA_W-1:0]    element_out;
		logic                 found;
		logic                 rejected;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 is_empty;
	} rsp_t;

endpackage

// ===== src/plt_if.sv =====
// ----------------------------------------------------------------------------
// plt_req_if / plt_rsp_if
// Valid/ready channels carrying list requests and their results.
// ----------------------------------------------------------------------------
interface plt_req_if import plt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] element_in;

	modport source (output valid, kind, position, element_in, input ready);
	modport sink   (input valid, kind, position, element_in, output ready);
endinterface

interface plt_rsp_if import plt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [DATA_W-1:0]    element_out;
	logic                 found;
	logic                 rejected;
	logic [CNT_OUT_W-1:0] entry_count;
	logic                 is_empty;

	modport source (output valid, element_out, found, rejected, entry_count, is_empty,
		input ready);
	modport sink   (input valid, element_out, found, rejected, entry_count, is_empty,
		output ready);
endinterface

// ===== src/plt_ram.sv =====
// ----------------------------------------------------------------------------
// plt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module plt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/plt_seq.sv =====
// ----------------------------------------------------------------------------
// plt_seq
// Request sequencer: decodes one request, walks the slot memory to shift
// entries on insert and remove, and keeps count and cursor.
// ----------------------------------------------------------------------------
module plt_seq import plt_pkg::*; #(
	parameter int LIST_DEPTH   = DEFAULT_LIST_DEPTH,
	parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [KIND_W-1:0]             req_kind,
	input  logic [POS_W-1:0]              req_position,
	input  logic [DATA_W-1:0]             req_element,
	output logic                          res_valid,
	input  logic                          res_take,
	output rsp_t                          res,
	output logic                          mem_wr_en,
	output logic [$clog2(LIST_DEPTH)-1:0] mem_wr_addr,
	output logic [ELEMENT_BITS-1:0]       mem_wr_data,
	output logic                          mem_rd_en,
	output logic [$clog2(LIST_DEPTH)-1:0] mem_rd_addr,
	input  logic [ELEMENT_BITS-1:0]       mem_rd_data
);

	localparam int AW   = $clog2(LIST_DEPTH);
	localparam int CW   = $clog2(LIST_DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CAPTURE,
		S_SHIFT_UP,
		S_SHIFT_DOWN,
		S_DRAIN,
		S_WRITE,
		S_DONE
	} state_t;

	state_t                  state_q;
	kind_t                   kind_q;
	logic [POS_W-1:0]        pos_q;
	logic [ELEMENT_BITS-1:0] elem_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           cidx_q;
	logic                    cval_q;
	logic [AW-1:0]           ptr_q;
	logic                    pend_s1;
	logic [AW-1:0]           waddr_s1;
	logic [ELEMENT_BITS-1:0] result_q;
	logic                    found_q;
	logic                    rejected_q;

	logic          full;
	logic          pos_lt;
	logic          rem_shift;
	logic          next_ok;
	logic [AW-1:0] pos_a;
	logic [AW-1:0] last_a;

	assign full      = (count_q == CW'(LIST_DEPTH));
	assign pos_lt    = (CMPW'(pos_q) < CMPW'(count_q));
	assign rem_shift = ((CMPW'(pos_q) + CMPW'(1)) < CMPW'(count_q));
	assign next_ok   = cval_q && (cidx_q < count_q);
	assign pos_a     = AW'(pos_q);
	assign last_a    = AW'(count_q - CW'(1));

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.element_out = DATA_W'(result_q);
		res.found       = found_q;
		res.rejected    = rejected_q;
		res.entry_count = CNT_OUT_W'(count_q);
		res.is_empty    = (count_q == '0);
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q;
		mem_wr_en   = pend_s1;
		mem_wr_addr = waddr_s1;
		mem_wr_data = mem_rd_data;
		unique case (state_q) inside
			S_DECODE: begin
				unique case (kind_q) inside
					KIND_APPEND, KIND_INSERT: begin
						if (!full && (kind_q == KIND_APPEND || !pos_lt)) begin
							mem_wr_en   = 1'b1;
							mem_wr_addr = AW'(count_q);
							mem_wr_data = elem_q;
						end
					end
					KIND_REMOVE, KIND_READ: begin
						mem_rd_en   = pos_lt;
						mem_rd_addr = pos_a;
					end
					KIND_NEXT: begin
						mem_rd_en   = next_ok;
						mem_rd_addr = AW'(cidx_q);
					end
					default: begin
					end
				endcase
			end
			S_SHIFT_UP, S_SHIFT_DOWN: begin
				mem_rd_en = 1'b1;
			end
			S_WRITE: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = pos_a;
				mem_wr_data = elem_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= KIND_APPEND;
			pos_q      <= '0;
			elem_q     <= '0;
			count_q    <= '0;
			cidx_q     <= '0;
			cval_q     <= 1'b0;
			ptr_q      <= '0;
			pend_s1    <= 1'b0;
			waddr_s1   <= '0;
			result_q   <= '0;
			found_q    <= 1'b0;
			rejected_q <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q  <= kind_t'(req_kind);
						pos_q   <= req_position;
						elem_q  <= ELEMENT_BITS'(req_element);
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					result_q   <= '0;
					found_q    <= 1'b0;
					rejected_q <= 1'b0;
					state_q    <= S_DONE;
					unique case (kind_q) inside
						KIND_APPEND, KIND_INSERT: begin
							if (full) begin
								rejected_q <= 1'b1;
							end else if (kind_q == KIND_INSERT && pos_lt) begin
								ptr_q   <= last_a;
								cidx_q  <= CW'(pos_q) + CW'(1);
								cval_q  <= 1'b1;
								state_q <= S_SHIFT_UP;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						KIND_REMOVE: begin
							if (pos_lt) begin
								cidx_q  <= '0;
								cval_q  <= 1'b0;
								state_q <= S_CAPTURE;
							end
						end
						KIND_READ: begin
							if (pos_lt) begin
								cidx_q  <= CW'(pos_q);
								cval_q  <= 1'b1;
								state_q <= S_CAPTURE;
							end else begin
								cidx_q <= '0;
								cval_q <= 1'b0;
							end
						end
						KIND_REWIND: begin
							cidx_q <= '0;
							cval_q <= (count_q != '0);
						end
						KIND_NEXT: begin
							if (next_ok) begin
								if ((cidx_q + CW'(1)) >= count_q) begin
									cidx_q <= '0;
									cval_q <= 1'b0;
								end else begin
									cidx_q <= cidx_q + CW'(1);
								end
								state_q <= S_CAPTURE;
							end else begin
								cidx_q <= '0;
								cval_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				S_CAPTURE: begin
					result_q <= mem_rd_data;
					found_q  <= 1'b1;
					state_q  <= S_DONE;
					if (kind_q == KIND_REMOVE) begin
						if (rem_shift) begin
							ptr_q   <= AW'(CMPW'(pos_q) + CMPW'(1));
							state_q <= S_SHIFT_DOWN;
						end else begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				S_SHIFT_UP: begin
					pend_s1  <= 1'b1;
					waddr_s1 <= ptr_q + AW'(1);
					if (ptr_q == pos_a) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				S_SHIFT_DOWN: begin
					pend_s1  <= 1'b1;
					waddr_s1 <= ptr_q - AW'(1);
					if (ptr_q == last_a) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_DRAIN: begin
					if (kind_q == KIND_INSERT) begin
						state_q <= S_WRITE;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_WRITE: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/positional_list_table_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_table_core
// Bounded ordered list of element words addressed by position.
// ----------------------------------------------------------------------------
// Requests arrive on req (kind, position, element_in) and each gives exactly
// one result on rsp (element_out, found, rejected, entry_count, is_empty).
// Both channels use valid/ready; a request is taken when both are high.
// Elements live in one single-port-read, single-port-write RAM; the
// sequencer handles one request at a time.
// Appends, inserts at or above the count, rejected requests, rewinds,
// unused kinds, and reads, read nexts or removes that find nothing need no
// RAM read. Read, read next and remove of the last entry read the RAM once;
// insert below the count and remove below the last entry shift the entries
// through the RAM, one RAM read per entry moved, and take the longest.
// The result appears on rsp in the same cycle as the sequencer becomes
// ready for the next request.
// Reset empties the list and clears the cursor; RAM contents stay as they
// are and are never read before being written. A stalled rsp holds its
// result in the output register; the sequencer takes one more request and
// then waits until the register is free.
// ----------------------------------------------------------------------------
module positional_list_table_core import plt_pkg::*; #(
	parameter int LIST_DEPTH   = DEFAULT_LIST_DEPTH,
	parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	plt_req_if.sink   req,
	plt_rsp_if.source rsp
);

	localparam int AW = $clog2(LIST_DEPTH);

	logic                    mem_wr_en;
	logic [AW-1:0]           mem_wr_addr;
	logic [ELEMENT_BITS-1:0] mem_wr_data;
	logic                    mem_rd_en;
	logic [AW-1:0]           mem_rd_addr;
	logic [ELEMENT_BITS-1:0] mem_rd_data;

	logic res_valid;
	logic res_take;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_data_q;

	plt_seq #(
		.LIST_DEPTH   (LIST_DEPTH),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_ready    (req.ready),
		.req_kind     (req.kind),
		.req_position (req.position),
		.req_element  (req.element_in),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data)
	);

	plt_ram #(
		.WIDTH (ELEMENT_BITS),
		.DEPTH (LIST_DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign res_take = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			if (res_valid && res_take) begin
				rsp_valid_q <= 1'b1;
				rsp_data_q  <= res;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.element_out = rsp_data_q.element_out;
	assign rsp.found       = rsp_data_q.found;
	assign rsp.rejected    = rsp_data_q.rejected;
	assign rsp.entry_count = rsp_data_q.entry_count;
	assign rsp.is_empty    = rsp_data_q.is_empty;

endmodule

// ===== src/plt_checker.sv =====
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks on the results of the positional list table.
// ----------------------------------------------------------------------------
module plt_checker import plt_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [DATA_W-1:0]    element_out,
	input logic                 found,
	input logic                 rejected,
	input logic [CNT_OUT_W-1:0] entry_count,
	input logic                 is_empty
);

	a_found_xor_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(found && rejected))
		else $error("result both found and rejected");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_zero_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !found) |-> (element_out == '0))
		else $error("element returned without found");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(element_out)))
		else $error("stalled result dropped or changed");

endmodule

bind positional_list_table_core plt_checker u_plt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.element_out (rsp.element_out),
	.found       (rsp.found),
	.rejected    (rsp.rejected),
	.entry_count (rsp.entry_count),
	.is_empty    (rsp.is_empty)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list table core.
// ----------------------------------------------------------------------------
// A list predictor built into the bench tracks the stored elements, the count
// and the cursor. Each accepted request queues one expected result, and each
// accepted result is checked field by field against the oldest entry. A short
// directed table runs first. Random episodes follow: fill to full with
// rejected extras, drain by random removes, cursor scans and mixed traffic.
// Both channels idle at random. The bench also forces one long result stall
// and one wait until all pending results have drained while the run is in progress.
// ----------------------------------------------------------------------------
module tb;
	import plt_pkg::*;

	localparam int LIST_DEPTH    = DEFAULT_LIST_DEPTH;
	localparam int ITEM_TARGET   = 1800;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] element;
		bit                fixed;
		rsp_t              fixed_rsp;
	} list_step_t;

	logic clk = 1'b0;
	logic arst_n;

	plt_req_if req_ch ();
	plt_rsp_if rsp_ch ();

	positional_list_table_core #(
		.LIST_DEPTH   (DEFAULT_LIST_DEPTH),
		.ELEMENT_BITS (DEFAULT_ELEMENT_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [DATA_W-1:0] list_slots [LIST_DEPTH];
	int                list_count;
	int                cursor_idx;
	bit                cursor_ok;

	rsp_t       pending_results [$];
	list_step_t directed_steps [$];
	rsp_t       result_want;
	int         mismatches;
	int         sent_count;
	longint     cycle_count;
	bit         tx_calm;
	bit         rx_calm;
	bit         rsp_hold_pending;
	int         rsp_hold_left;
	int         rsp_stall_left;
	int         stall_roll;

	always #5 clk = ~clk;

	function automatic list_step_t step_row(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] element, bit fixed = 1'b0, int x_count = 0,
			bit x_found = 1'b0, logic [DATA_W-1:0] x_element = '0, bit x_rejected = 1'b0);
		list_step_t row;
		row.kind                  = kind;
		row.position              = pos;
		row.element               = element;
		row.fixed                 = fixed;
		row.fixed_rsp.element_out = x_element;
		row.fixed_rsp.found       = x_found;
		row.fixed_rsp.rejected    = x_rejected;
		row.fixed_rsp.entry_count = CNT_OUT_W'(x_count);
		row.fixed_rsp.is_empty    = (x_count == 0);
		return row;
	endfunction

	task automatic apply_list_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] element, output rsp_t r);
		int p;
		p = int'(pos);
		r = '0;
		case (kind) inside
			KIND_APPEND, KIND_INSERT: begin
				if (list_count >= LIST_DEPTH) begin
					r.rejected = 1'b1;
				end else if (kind == KIND_APPEND || p >= list_count) begin
					list_slots[list_count] = element;
					list_count++;
				end else begin
					for (int i = list_count; i > p; i--)
						list_slots[i] = list_slots[i-1];
					list_slots[p] = element;
					list_count++;
					cursor_idx = p + 1;
					cursor_ok  = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (p < list_count) begin
					r.element_out = list_slots[p];
					r.found       = 1'b1;
					for (int i = p; i + 1 < list_count; i++)
						list_slots[i] = list_slots[i+1];
					list_count--;
					cursor_idx = 0;
					cursor_ok  = 1'b0;
				end
			end
			KIND_READ: begin
				if (p < list_count) begin
					r.element_out = list_slots[p];
					r.found       = 1'b1;
					cursor_idx    = p;
					cursor_ok     = 1'b1;
				end else begin
					cursor_idx = 0;
					cursor_ok  = 1'b0;
				end
			end
			KIND_REWIND: begin
				cursor_idx = 0;
				cursor_ok  = (list_count != 0);
			end
			KIND_NEXT: begin
				if (cursor_ok && cursor_idx < list_count) begin
					r.element_out = list_slots[cursor_idx];
					r.found       = 1'b1;
					cursor_idx++;
					if (cursor_idx >= list_count) begin
						cursor_idx = 0;
						cursor_ok  = 1'b0;
					end
				end else begin
					cursor_idx = 0;
					cursor_ok  = 1'b0;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = CNT_OUT_W'(list_count);
		r.is_empty    = (list_count == 0);
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (tx_calm || roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [POS_W-1:0] pick_position(bit in_range, int span);
		if (in_range && span > 0)
			return POS_W'($urandom_range(0, span - 1));
		return POS_W'($urandom_range(0, 63));
	endfunction

	function automatic logic [DATA_W-1:0] rand_element();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		return DATA_W'($urandom());
	endfunction

	task automatic pause_request(input int cycles);
		if (cycles > 0) begin
			req_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] element, input bit fixed = 1'b0,
			input rsp_t fixed_rsp = '0);
		rsp_t predicted;
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= kind;
		req_ch.position   <= pos;
		req_ch.element_in <= element;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		apply_list_op(kind, pos, element, predicted);
		pending_results.push_back(fixed ? fixed_rsp : predicted);
		if (kind != KIND_UNUSED_6 && kind != KIND_UNUSED_7)
			sent_count++;
		pause_request(pick_gap());
	endtask

	task automatic wait_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic mixed_burst(input int n);
		int roll;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 20)
				send_request(KIND_APPEND, pick_position(1'b0, 0), rand_element());
			else if (roll < 40)
				send_request(KIND_INSERT, pick_position($urandom_range(0, 3) != 0,
					list_count + 1), rand_element());
			else if (roll < 60)
				send_request(KIND_REMOVE, pick_position($urandom_range(0, 3) != 0,
					list_count), rand_element());
			else if (roll < 80)
				send_request(KIND_READ, pick_position($urandom_range(0, 3) != 0,
					list_count), rand_element());
			else if (roll < 88)
				send_request(KIND_REWIND, pick_position(1'b0, 0), rand_element());
			else if (roll < 98)
				send_request(KIND_NEXT, pick_position(1'b0, 0), rand_element());
			else
				send_request($urandom_range(0, 1) ? KIND_UNUSED_7 : KIND_UNUSED_6,
					pick_position(1'b0, 0), rand_element());
		end
	endtask

	task automatic fill_list();
		while (list_count < LIST_DEPTH) begin
			if ($urandom_range(0, 1))
				send_request(KIND_APPEND, pick_position(1'b0, 0), rand_element());
			else
				send_request(KIND_INSERT, pick_position(1'b1, list_count + 1),
					rand_element());
		end
		repeat ($urandom_range(2, 4))
			send_request($urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND,
				pick_position(1'b0, 0), rand_element());
	endtask

	task automatic drain_list();
		while (list_count > 0)
			send_request(KIND_REMOVE, pick_position($urandom_range(0, 9) != 0, list_count),
				rand_element());
		send_request(KIND_REMOVE, pick_position(1'b0, 0), rand_element());
	endtask

	task automatic scan_list();
		if ($urandom_range(0, 1))
			send_request(KIND_READ, pick_position(1'b1, list_count), rand_element());
		else
			send_request(KIND_REWIND, pick_position(1'b0, 0), rand_element());
		while (cursor_ok)
			send_request(KIND_NEXT, pick_position(1'b0, 0), rand_element());
		send_request(KIND_NEXT, pick_position(1'b0, 0), rand_element());
	endtask

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none pending, actual element_out %0h count %0d",
					$time, rsp_ch.element_out, rsp_ch.entry_count);
				mismatches++;
			end else begin
				result_want = pending_results.pop_front();
				check_field("element_out", result_want.element_out, rsp_ch.element_out);
				check_field("found", DATA_W'(result_want.found), DATA_W'(rsp_ch.found));
				check_field("rejected", DATA_W'(result_want.rejected),
					DATA_W'(rsp_ch.rejected));
				check_field("entry_count", DATA_W'(result_want.entry_count),
					DATA_W'(rsp_ch.entry_count));
				check_field("is_empty", DATA_W'(result_want.is_empty),
					DATA_W'(rsp_ch.is_empty));
			end
		end
		if (rsp_hold_pending) begin
			rsp_hold_left    = HOLD_CYCLES;
			rsp_hold_pending = 1'b0;
		end
		if (rsp_hold_left > 0) begin
			rsp_hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (rx_calm) begin
			rsp_ch.ready <= 1'b1;
		end else if (rsp_stall_left > 0) begin
			rsp_stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 70) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready   <= 1'b0;
				rsp_stall_left = (stall_roll < 95) ? $urandom_range(0, 2) :
					(stall_roll < 99) ? $urandom_range(3, 9) : $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int  episode;
		bit  hold_done;
		bit  drain_done;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.kind       = '0;
		req_ch.position   = '0;
		req_ch.element_in = '0;
		rsp_ch.ready      = 1'b0;
		list_count        = 0;
		cursor_idx        = 0;
		cursor_ok         = 1'b0;
		mismatches        = 0;
		sent_count        = 0;
		cycle_count       = 0;
		tx_calm           = 1'b0;
		rx_calm           = 1'b0;
		rsp_hold_pending  = 1'b0;
		rsp_hold_left     = 0;
		rsp_stall_left    = 0;
		hold_done         = 1'b0;
		drain_done        = 1'b0;

		directed_steps = '{
			step_row(KIND_READ,     6'd0,  32'h0000_0000, 1'b1, 0),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000, 1'b1, 0),
			step_row(KIND_REMOVE,   6'd63, 32'hFFFF_FFFF, 1'b1, 0),
			step_row(KIND_REWIND,   6'd0,  32'h0000_0000, 1'b1, 0),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000, 1'b1, 0),
			step_row(KIND_APPEND,   6'd0,  32'hFFFF_FFFF, 1'b1, 1),
			step_row(KIND_APPEND,   6'd63, 32'h0000_0000, 1'b1, 2),
			step_row(KIND_INSERT,   6'd63, 32'hA5A5_A5A5, 1'b1, 3),
			step_row(KIND_INSERT,   6'd0,  32'h5A5A_5A5A, 1'b1, 4),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000),
			step_row(KIND_READ,     6'd3,  32'h0000_0000),
			step_row(KIND_READ,     6'd4,  32'h0000_0000, 1'b1, 4),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000, 1'b1, 4),
			step_row(KIND_REWIND,   6'd0,  32'h0000_0000, 1'b1, 4),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000),
			step_row(KIND_INSERT,   6'd2,  32'h8000_0001),
			step_row(KIND_REMOVE,   6'd0,  32'h0000_0000),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000, 1'b1, 4),
			step_row(KIND_UNUSED_6, 6'd63, 32'hFFFF_FFFF, 1'b1, 4),
			step_row(KIND_UNUSED_7, 6'd0,  32'h0000_0000, 1'b1, 4),
			step_row(KIND_READ,     6'd3,  32'h0000_0000),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000),
			step_row(KIND_APPEND,   6'd21, 32'h1234_5678, 1'b1, 5),
			step_row(KIND_NEXT,     6'd0,  32'h0000_0000, 1'b1, 5),
			step_row(KIND_REMOVE,   6'd4,  32'h0000_0000)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i])
			send_request(directed_steps[i].kind, directed_steps[i].position,
				directed_steps[i].element, directed_steps[i].fixed,
				directed_steps[i].fixed_rsp);

		while (sent_count < ITEM_TARGET) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (!hold_done && sent_count >= 600) begin
				hold_done        = 1'b1;
				tx_calm          = 1'b1;
				rx_calm          = 1'b0;
				rsp_hold_pending = 1'b1;
				mixed_burst(24);
			end else if (!drain_done && sent_count >= 1200) begin
				drain_done = 1'b1;
				wait_results();
			end else begin
				episode = $urandom_range(0, 9);
				if (episode < 2)
					fill_list();
				else if (episode < 4)
					drain_list();
				else if (episode < 6)
					scan_list();
				else
					mixed_burst($urandom_range(10, 40));
			end
		end

		wait_results();
		repeat (LIST_DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/plt_pkg.sv
src/plt_if.sv
src/plt_ram.sv
src/plt_seq.sv
src/positional_list_table_core.sv
src/plt_checker.sv
tb/sv/tb.sv
